[sv/bb3_pkg.sv]
// Shared types, register codes and divider constants for the 3x3 RGB box blur.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  // One RGB pixel: red in the top byte, blue in the bottom byte
  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_end;
  } out_item_t;

  // Neighbor mask of the 3x3 window: bit 0 is the top row / left column
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } mask_t;

  // Item modes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam int FW_BITS = 11;
  localparam int FH_BITS = 13;
  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

  // Averaging datapath: nine 8-bit terms, divisor by reciprocal multiply
  localparam int SUM_W   = 12;
  localparam int CNT_W   = 4;
  localparam int RECIP_W = 17;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // Rounded-up 2^16/n; exact floor quotient for every sum below 2^15
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/bb3_avg.sv]
// Masked 3x3 per-channel sum and constant-divisor average, two register stages.
`timescale 1ns / 1ps
`default_nettype none

module bb3_avg (
  input  logic                     clk,
  input  bb3_pkg::pix_t [2:0][2:0] win,
  input  bb3_pkg::mask_t           mask,
  output bb3_pkg::pix_t            avg_pix
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]   sum_nxt [3];
  logic [SUM_W-1:0]   sum_r   [3];
  logic [1:0]         rows_n;
  logic [1:0]         cols_n;
  logic [CNT_W-1:0]   cnt;
  logic [RECIP_W-1:0] recip_r;
  logic [PROD_W-1:0]  prod_r  [3];

  // Add up the in-frame neighbors per channel and count them
  always_comb begin
    rows_n = 2'($countones(mask.row));
    cols_n = 2'($countones(mask.col));
    cnt    = CNT_W'(rows_n) * CNT_W'(cols_n);
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (mask.row[i] && mask.col[j]) begin
            sum_nxt[k] = sum_nxt[k] + SUM_W'(win[i][j][8*k +: 8]);
          end
        end
      end
    end
  end

  // Stage 1 holds sums and reciprocal, stage 2 the products
  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    recip_r <= recip_of(cnt);
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= PROD_W'(sum_r[k]) * PROD_W'(recip_r);
    end
  end

  // Drop the fraction bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      avg_pix[8*k +: 8] = prod_r[k][FRAC_W +: 8];
    end
  end

endmodule

`default_nettype wire

[sv/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB box blur with two line stores.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item  (mode, blue/green/red_in)
//   out      output     out_valid/out_stall  out_item (blue/green/red_out, frame_end)
//   cfg      input      cfg_we               cfg_idx, cfg_wdata
//
// One item at a time through a sequencer around the line stores and one shared
// averaging unit. A dropped item leaves it idle; a push passes S_PUSH, then S_AVG0,
// S_AVG1 and S_EMIT per result (zero to two); a flush passes S_FL0 to S_FL2, then
// those three for its one result. S_AVG0 and S_AVG1 cover the averaging unit's sum
// and multiply stages. Reset is synchronous: counters restart, width and height
// return to 640 and 480; the line stores are not cleared. out_stall holds a finished
// result in the emit state; in_stall is high whenever the sequencer is busy.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bb3_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bb3_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PUSH = 8'b0000_0010,
    S_FL0  = 8'b0000_0100,
    S_FL1  = 8'b0000_1000,
    S_FL2  = 8'b0001_0000,
    S_AVG0 = 8'b0010_0000,
    S_AVG1 = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [FW_BITS-1:0] fw_r;
  logic [FH_BITS-1:0] fh_r;
  logic [WW-1:0]      w_eff;
  logic [RW-1:0]      h_eff;

  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] drain_r, drain_nxt;

  logic          in_acc;
  logic          is_flush_in;
  logic          push_ok;
  logic          flush_ok;
  logic          item_ok;
  logic          take;
  logic [CW-1:0] cur_col;
  logic          cur_last;
  logic          cur_ge1;
  logic          cur_ge2;

  pix_t          pix_r;
  logic [CW-1:0] item_col_r;
  logic          is_flush_r;
  logic          r_ge1_r;
  logic          r_ge2_r;
  logic          c_ge1_r;
  logic          c_ge2_r;
  logic          c_last_r;
  logic          pend2_r;
  mask_t         mask_r;

  pix_t [2:0][2:0] window_r;
  pix_t [2:0]      new_col;
  logic            shift_en;

  pix_t          upper_mem  [MAX_WIDTH];
  pix_t          middle_mem [MAX_WIDTH];
  pix_t          up_rd_r;
  pix_t          mid_rd_r;
  logic [CW-1:0] rd_addr;
  logic          mem_we;

  pix_t      avg_pix;
  logic      out_load;
  logic      out_valid_r;
  out_item_t out_r;

  // Clamp the frame size registers into the supported range
  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = RW'(1);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(fh_r);
    end
  end

  // Classify the offered item
  assign in_acc      = in_valid && !in_stall;
  assign is_flush_in = (in_item.mode == MODE_FLUSH);
  assign push_ok     = (row_cnt_r < h_eff) && (WW'(col_cnt_r) < w_eff);
  assign flush_ok    = (row_cnt_r >= h_eff) && (WW'(drain_r) < w_eff);
  assign item_ok     = is_flush_in ? flush_ok : push_ok;
  assign take        = in_acc && item_ok;
  assign cur_col     = is_flush_in ? drain_r : col_cnt_r;
  assign cur_last    = (WW'(cur_col) + WW'(1)) == w_eff;
  assign cur_ge1     = (cur_col != '0);
  assign cur_ge2     = (cur_col >= CW'(2));

  // Advance raster and drain positions; a register write restarts the frame
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    drain_nxt   = drain_r;
    if (cfg_we) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
      drain_nxt   = '0;
    end else if (take) begin
      if (!is_flush_in) begin
        if (cur_last) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = row_cnt_r + RW'(1);
        end else begin
          col_cnt_nxt = col_cnt_r + CW'(1);
        end
      end else if (cur_last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
        drain_nxt   = '0;
      end else begin
        drain_nxt = drain_r + CW'(1);
      end
    end
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = is_flush_in ? S_FL0 : S_PUSH;
        end
      end
      S_PUSH: begin
        state_nxt = (r_ge1_r && (c_ge1_r || c_last_r)) ? S_AVG0 : S_IDLE;
      end
      S_FL0:  state_nxt = S_FL1;
      S_FL1:  state_nxt = S_FL2;
      S_FL2:  state_nxt = S_AVG0;
      S_AVG0: state_nxt = S_AVG1;
      S_AVG1: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_nxt = pend2_r ? S_AVG0 : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // Line store read address: push column, or left/center/right drain column
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        if (is_flush_in) begin
          rd_addr = (drain_r == '0) ? '0 : drain_r - CW'(1);
        end else begin
          rd_addr = col_cnt_r;
        end
      end
      S_FL1:   rd_addr = c_last_r ? item_col_r : item_col_r + CW'(1);
      default: rd_addr = item_col_r;
    endcase
  end

  // Line stores: upper takes the old middle entry, middle takes the new pixel
  assign mem_we = (state_r == S_PUSH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[item_col_r] <= mid_rd_r;
    end
    up_rd_r <= upper_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      middle_mem[item_col_r] <= pix_r;
    end
    mid_rd_r <= middle_mem[rd_addr];
  end

  // New window column: upper row, middle row, incoming pixel (zero outside a push)
  always_comb begin
    new_col[0] = up_rd_r;
    new_col[1] = mid_rd_r;
    new_col[2] = (state_r == S_PUSH) ? pix_r : '0;
  end

  assign shift_en = (state_r == S_PUSH) || (state_r == S_FL0) ||
                    (state_r == S_FL1) || (state_r == S_FL2);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fw_r        <= FW_RESET;
      fh_r        <= FH_RESET;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      drain_r     <= '0;
      pend2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      drain_r   <= drain_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_FRAME_WIDTH:  fw_r <= cfg_wdata[FW_BITS-1:0];
          REG_FRAME_HEIGHT: fh_r <= cfg_wdata[FH_BITS-1:0];
          default: ;
        endcase
      end
      if (state_r == S_PUSH) begin
        pend2_r <= r_ge1_r && c_ge1_r && c_last_r;
      end else if (out_load) begin
        pend2_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, window, mask and result registers
  always_ff @(posedge clk) begin
    // Latch the accepted item and its position flags
    if (state_r == S_IDLE && take) begin
      pix_r      <= {in_item.red_in, in_item.green_in, in_item.blue_in};
      item_col_r <= cur_col;
      is_flush_r <= is_flush_in;
      r_ge1_r    <= (row_cnt_r != '0);
      r_ge2_r    <= is_flush_in ? (h_eff >= RW'(2)) : (row_cnt_r >= RW'(2));
      c_ge1_r    <= cur_ge1;
      c_ge2_r    <= cur_ge2;
      c_last_r   <= cur_last;
      if (is_flush_in) begin
        mask_r.row <= {1'b0, 1'b1, h_eff >= RW'(2)};
        mask_r.col <= {!cur_last, 1'b1, cur_ge1};
      end
    end
    // Pick the first push result's neighbors, or the right-edge one alone
    if (state_r == S_PUSH) begin
      mask_r.row <= {1'b1, 1'b1, r_ge2_r};
      if (c_ge1_r) begin
        mask_r.col <= {1'b1, 1'b1, c_ge2_r};
      end else begin
        mask_r.col <= {1'b1, 1'b0, 1'b0};
      end
    end
    // Right-edge result after the regular one: keep the two newest columns
    if (out_load && pend2_r) begin
      mask_r.col <= {1'b1, c_ge1_r, 1'b0};
    end
    // Shift the window one column left
    if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        window_r[i][0] <= window_r[i][1];
        window_r[i][1] <= window_r[i][2];
        window_r[i][2] <= new_col[i];
      end
    end
    if (out_load) begin
      out_r.blue_out  <= avg_pix[7:0];
      out_r.green_out <= avg_pix[15:8];
      out_r.red_out   <= avg_pix[23:16];
      out_r.frame_end <= is_flush_r && c_last_r;
    end
  end

  bb3_avg u_avg (
    .clk     (clk),
    .win     (window_r),
    .mask    (mask_r),
    .avg_pix (avg_pix)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Line stores are written only right after a push was taken
  a_push_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> $past(in_valid && !in_stall && in_item.mode == MODE_PUSH))
    else $error("line store write without a preceding push");

  // The raster column never reaches the clamped frame width
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_cnt_r) < w_eff)
    else $error("column counter beyond frame width");

  // Draining only starts once every row has been pushed
  a_drain_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_r != '0) |-> (row_cnt_r >= h_eff))
    else $error("drain position advanced before frame complete");

endmodule

`default_nettype wire
